// ===== rtl/frr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_pkg
// Types, constants and the control store of the forest root resolver.
// ----------------------------------------------------------------------------
package frr_pkg;

	// width of a node index on the item channels
	localparam int unsigned IDX_W = 12;

	// function codes of an input item
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// input item
	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] node;
		logic [IDX_W-1:0] parent;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [IDX_W-1:0] queried_node;
		logic [IDX_W-1:0] root;
		logic             no_root;
	} out_item_t;

	// microprogram steps
	typedef enum logic [1:0] {
		STEP_IDLE,
		STEP_CHECK,
		STEP_COMPARE,
		STEP_EMIT
	} step_t;

	// jump conditions
	typedef enum logic [1:0] {
		COND_QUERY,
		COND_STOP,
		COND_HIT,
		COND_OUT_FREE
	} cond_t;

	// one control word
	typedef struct packed {
		logic  take;     // accept an input item in this step
		logic  rd;       // read the table at the current node
		logic  adv;      // step the walk to the fetched parent
		logic  emit;     // hand the result to the output register
		cond_t cond;     // jump condition
		step_t on_true;  // next step when the condition holds
		step_t on_false; // next step otherwise
	} ctrl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic query; // query item accepted
		logic stop;  // step cap reached or node out of range
		logic hit;   // fetched parent equals current node
	} dp_stat_t;

	// control store
	function automatic ctrl_t microcode(input step_t step);
		ctrl_t w;
		w = '{take: 1'b0, rd: 1'b0, adv: 1'b0, emit: 1'b0, cond: COND_QUERY,
			on_true: STEP_IDLE, on_false: STEP_IDLE};
		case (step)
			STEP_IDLE: begin
				w.take     = 1'b1;
				w.cond     = COND_QUERY;
				w.on_true  = STEP_CHECK;
				w.on_false = STEP_IDLE;
			end
			STEP_CHECK: begin
				w.rd       = 1'b1;
				w.cond     = COND_STOP;
				w.on_true  = STEP_EMIT;
				w.on_false = STEP_COMPARE;
			end
			STEP_COMPARE: begin
				w.adv      = 1'b1;
				w.cond     = COND_HIT;
				w.on_true  = STEP_EMIT;
				w.on_false = STEP_CHECK;
			end
			STEP_EMIT: begin
				w.emit     = 1'b1;
				w.cond     = COND_OUT_FREE;
				w.on_true  = STEP_IDLE;
				w.on_false = STEP_EMIT;
			end
			default: begin
				w.cond     = COND_QUERY;
				w.on_true  = STEP_IDLE;
				w.on_false = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/forest_root_resolver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forest_root_resolver_core
// Parent table with on-demand root lookup: write items store parent links,
// query items walk the parent chain to the self-parented root or stop early.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data      | write or query item
//  out     | out_valid, out_ready, out_data   | result item, one per query
//
//  a write item is taken in the idle step; a query holds the block until its
//  walk ends at a root or stops early
//  each walk step is one registered read of the single-port table, then the
//  compare and pointer update
//  reset clears the sequencer and output valid; the table is not cleared
//  a full output register holds a finished query in its emit step, input off
// ----------------------------------------------------------------------------
module forest_root_resolver_core #(
	parameter int unsigned NODES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  frr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output frr_pkg::out_item_t out_data
);

	frr_pkg::ctrl_t     ctrl;
	frr_pkg::dp_stat_t  stat;
	frr_pkg::out_item_t result;
	frr_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               out_free;
	logic               out_load;

	// sequencer
	frr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// datapath and table
	frr_datapath #(
		.NODES (NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.in_valid (in_valid),
		.in_item  (in_data),
		.stat     (stat),
		.result   (result)
	);

	// handshake glue
	assign in_ready  = ctrl.take;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_load  = ctrl.emit & out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

`ifndef ASSERT_OFF
	// an emitted result shows up on the output next cycle
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("emitted result not presented");

	// an accepted query blocks further input while it walks
	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.func == frr_pkg::FUNC_QUERY) |=> !in_ready)
		else $error("input taken during a walk");
`endif

endmodule

// ===== rtl/frr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_seq
// Step counter and control store: issues one control word per cycle and
// jumps on the condition that the word selects.
// ----------------------------------------------------------------------------
module frr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  frr_pkg::dp_stat_t stat,
	input  logic              out_free,
	output frr_pkg::ctrl_t    ctrl
);

	frr_pkg::step_t pc_q;
	frr_pkg::step_t pc_d;
	logic           cond_met;

	// condition select
	always_comb begin
		case (ctrl.cond)
			frr_pkg::COND_QUERY:    cond_met = stat.query;
			frr_pkg::COND_STOP:     cond_met = stat.stop;
			frr_pkg::COND_HIT:      cond_met = stat.hit;
			frr_pkg::COND_OUT_FREE: cond_met = out_free;
			default:                cond_met = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		pc_d = cond_met ? ctrl.on_true : ctrl.on_false;
	end

	// control word of the current step
	always_comb begin
		ctrl = frr_pkg::microcode(pc_q);
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= frr_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== rtl/frr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_datapath
// Parent table memory, walk registers and step counter of the resolver.
// ----------------------------------------------------------------------------
module frr_datapath #(
	parameter int unsigned NODES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  frr_pkg::ctrl_t     ctrl,
	input  logic               in_valid,
	input  frr_pkg::in_item_t  in_item,
	output frr_pkg::dp_stat_t  stat,
	output frr_pkg::out_item_t result
);

	localparam int unsigned TBL_MAX = 1 << frr_pkg::IDX_W;
	localparam int unsigned DEPTH   = (NODES < TBL_MAX) ? NODES : TBL_MAX;
	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned SW      = $clog2(NODES + 1);
	localparam int unsigned RW      = (SW > frr_pkg::IDX_W) ? SW : frr_pkg::IDX_W;

	logic [frr_pkg::IDX_W-1:0] mem_q [DEPTH];
	logic [frr_pkg::IDX_W-1:0] rdata_q;
	logic [frr_pkg::IDX_W-1:0] cur_q;
	logic [frr_pkg::IDX_W-1:0] node_q;
	logic [SW-1:0]             steps_q;
	logic                      flag_q;
	logic                      accept;
	logic                      node_ok;
	logic                      cur_ok;
	logic                      wr_en;

	// range checks against the node count
	assign accept  = ctrl.take & in_valid;
	assign node_ok = RW'(in_item.node) < RW'(NODES);
	assign cur_ok  = RW'(cur_q) < RW'(NODES);
	assign wr_en   = accept & (in_item.func == frr_pkg::FUNC_WRITE) & node_ok;

	// status to the sequencer
	always_comb begin
		stat.query = accept & (in_item.func == frr_pkg::FUNC_QUERY);
		stat.stop  = (steps_q == SW'(NODES)) | ~cur_ok;
		stat.hit   = (rdata_q == cur_q);
	end

	// parent table, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[in_item.node[AW-1:0]] <= in_item.parent;
		end
		if (ctrl.rd) begin
			rdata_q <= mem_q[cur_q[AW-1:0]];
		end
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			node_q  <= '0;
			steps_q <= '0;
			flag_q  <= 1'b0;
		end else if (stat.query) begin
			cur_q   <= in_item.node;
			node_q  <= in_item.node;
			steps_q <= '0;
			flag_q  <= 1'b1;
		end else if (ctrl.adv) begin
			cur_q   <= rdata_q;
			steps_q <= steps_q + 1'b1;
			if (stat.hit) begin
				flag_q <= 1'b0;
			end
		end
	end

	// result of the finished walk
	always_comb begin
		result.queried_node = node_q;
		result.root         = cur_q;
		result.no_root      = flag_q;
	end

`ifndef ASSERT_OFF
	// a walk step is only ever taken below the step cap
	a_steps_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.adv |-> (steps_q < SW'(NODES)))
		else $error("walk stepped past the cap");

	// reaching a self-parent clears the no-root flag
	a_hit_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.adv && stat.hit) |=> !flag_q)
		else $error("root found but no_root still set");
`endif

endmodule
